>>> hdl/contiguous_block_allocator_unit_assert.svh
// Assertion macros shared by the allocator checker.
// Depends on nothing; include guard keeps a single copy.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hdl/cba_pkg.sv
// Package for the contiguous block allocator: request/result types and codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cba_pkg;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_NO_RUN   = 3'd2,
        ST_BAD_IDX  = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_NULL     = 3'd5
    } t_status;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [13:0] request_bytes;
        logic [7:0]  block_index;
        logic        null_handle;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] first_block;
        logic [8:0] block_count;
    } t_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_DECODE,
        S_POP_RD,
        S_POP_WR,
        S_SORT_RD_I,
        S_SORT_WAIT_I,
        S_SORT_RD_J,
        S_SORT_CMP,
        S_SORT_PUT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_CMP_RD,
        S_CMP_WR,
        S_REC,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE_WR,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

>>> hdl/contiguous_block_allocator_unit.sv
// Top level of the contiguous block allocator: sequencer plus two memories.
// Depends on cba_pkg, cba_ram and cba_ctrl.
//
// Usage: drive i_req and raise start while busy is low; the request is
// taken at that edge. One result appears on o_rsp for one cycle with
// o_done high; the receiver cannot stall it.
// Steps: results that need no memory access are decided at decode; a
// single-block allocate pops the head of the free list and shifts the rest
// down; a multi-block allocate runs an insertion sort over the free list,
// then a run scan and compaction; a free reads the recorded run length and,
// unless the list would overflow, appends the run to the end of the list.
// The free-list RAM has one read port and one write port.
// After reset the block runs a clearing pass over all BLOCKS entries that
// loads the free list with ascending indices and zeroes the run lengths;
// busy is high through it. Requests are taken again in the cycle after o_done.
`timescale 1ns / 1ps
`default_nettype none
module contiguous_block_allocator_unit
    import cba_pkg::*;
#(
    parameter int unsigned BLOCKS      = 256,
    parameter int unsigned BLOCK_BYTES = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);
    localparam int unsigned AW = $clog2(BLOCKS);
    localparam int unsigned CW = $clog2(BLOCKS + 1);

    logic          fl_we, rl_we;
    logic [AW-1:0] fl_waddr, fl_wdata, fl_raddr, fl_rdata, rl_waddr, rl_raddr;
    logic [CW-1:0] rl_wdata, rl_rdata;

    // sequencer
    cba_ctrl #(.BLOCKS(BLOCKS), .BLOCK_BYTES(BLOCK_BYTES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_req(i_req),
        .o_busy(busy), .o_done(o_done), .o_rsp(o_rsp),
        .o_fl_we(fl_we), .o_fl_waddr(fl_waddr), .o_fl_wdata(fl_wdata),
        .o_fl_raddr(fl_raddr), .i_fl_rdata(fl_rdata),
        .o_rl_we(rl_we), .o_rl_waddr(rl_waddr), .o_rl_wdata(rl_wdata),
        .o_rl_raddr(rl_raddr), .i_rl_rdata(rl_rdata)
    );

    // free list storage
    cba_ram #(.WIDTH(AW), .DEPTH(BLOCKS)) u_free_list (
        .i_clk(i_clk), .i_we(fl_we), .i_waddr(fl_waddr), .i_wdata(fl_wdata),
        .i_raddr(fl_raddr), .o_rdata(fl_rdata)
    );

    // run length storage
    cba_ram #(.WIDTH(CW), .DEPTH(BLOCKS)) u_run_len (
        .i_clk(i_clk), .i_we(rl_we), .i_waddr(rl_waddr), .i_wdata(rl_wdata),
        .i_raddr(rl_raddr), .o_rdata(rl_rdata)
    );
endmodule
`default_nettype wire

>>> hdl/cba_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module cba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> hdl/cba_ctrl.sv
// Sequencer for the allocator: drives the free-list and run-length memories.
// Depends on cba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cba_ctrl
    import cba_pkg::*;
#(
    parameter int unsigned BLOCKS      = 256,
    parameter int unsigned BLOCK_BYTES = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  t_req                         i_req,
    output logic                         o_busy,
    output logic                         o_done,
    output t_rsp                         o_rsp,
    output logic                         o_fl_we,
    output logic [$clog2(BLOCKS)-1:0]    o_fl_waddr,
    output logic [$clog2(BLOCKS)-1:0]    o_fl_wdata,
    output logic [$clog2(BLOCKS)-1:0]    o_fl_raddr,
    input  wire  [$clog2(BLOCKS)-1:0]    i_fl_rdata,
    output logic                         o_rl_we,
    output logic [$clog2(BLOCKS)-1:0]    o_rl_waddr,
    output logic [$clog2(BLOCKS+1)-1:0]  o_rl_wdata,
    output logic [$clog2(BLOCKS)-1:0]    o_rl_raddr,
    input  wire  [$clog2(BLOCKS+1)-1:0]  i_rl_rdata
);
    localparam int unsigned AW = $clog2(BLOCKS);
    localparam int unsigned CW = $clog2(BLOCKS + 1);
    localparam int unsigned NW = 15;  // width of request_bytes/BLOCK_BYTES + 1
    localparam int unsigned EW = (CW > NW ? CW : NW) + 1;

    t_state r_state, n_state;
    t_req   r_req, n_req;
    t_rsp   r_rsp, n_rsp;
    logic [CW-1:0] r_cnt, n_cnt;     // free_count
    logic [CW-1:0] r_i, n_i;         // outer index
    logic [CW-1:0] r_j, n_j;         // inner index / write pointer
    logic [CW-1:0] r_start, n_start;
    logic [NW-1:0] r_len, n_len;
    logic [NW-1:0] r_need, n_need;
    logic [AW-1:0] r_v, n_v;         // held value
    logic [AW-1:0] r_first, n_first;
    logic [AW:0]   r_base, n_base;   // value at run start
    logic [CW-1:0] r_used, n_used;

    logic [NW-1:0] need_calc;
    assign need_calc = NW'(r_req.request_bytes / BLOCK_BYTES) + NW'(1);

    // state and data registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= CW'(BLOCKS);
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
        end
        r_req   <= n_req;
        r_rsp   <= n_rsp;
        r_j     <= n_j;
        r_start <= n_start;
        r_len   <= n_len;
        r_need  <= n_need;
        r_v     <= n_v;
        r_first <= n_first;
        r_base  <= n_base;
        r_used  <= n_used;
    end

    // next state, memory control and results
    always_comb begin
        n_state = r_state;
        n_req = r_req; n_rsp = r_rsp; n_cnt = r_cnt; n_i = r_i; n_j = r_j;
        n_start = r_start; n_len = r_len; n_need = r_need; n_v = r_v;
        n_first = r_first; n_base = r_base; n_used = r_used;
        o_fl_we = 1'b0; o_fl_waddr = '0; o_fl_wdata = '0; o_fl_raddr = '0;
        o_rl_we = 1'b0; o_rl_waddr = '0; o_rl_wdata = '0; o_rl_raddr = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            // clear pass: free list ascending, run lengths zero
            S_INIT: begin
                o_fl_we = 1'b1; o_fl_waddr = r_i[AW-1:0]; o_fl_wdata = r_i[AW-1:0];
                o_rl_we = 1'b1; o_rl_waddr = r_i[AW-1:0]; o_rl_wdata = '0;
                n_i = r_i + CW'(1);
                if (r_i == CW'(BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    n_req = i_req;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_rsp = '0;
                n_need = need_calc;
                if (r_req.cmd == CMD_ALLOC) begin
                    if (r_cnt == '0) begin
                        n_rsp.status = ST_EMPTY; n_state = S_DONE;
                    end else if (EW'(need_calc) > EW'(r_cnt)) begin
                        n_rsp.status = ST_NO_RUN; n_state = S_DONE;
                    end else if (need_calc == NW'(1)) begin
                        n_i = CW'(1);
                        n_state = S_POP_RD;
                    end else begin
                        n_i = CW'(1);
                        n_state = S_SORT_RD_I;
                    end
                end else begin
                    if (r_req.null_handle) begin
                        n_rsp.status = ST_NULL; n_state = S_DONE;
                    end else if (EW'(r_req.block_index) >= EW'(BLOCKS)) begin
                        n_rsp.status = ST_BAD_IDX; n_state = S_DONE;
                    end else begin
                        n_state = S_FREE_RD;
                    end
                end
            end
            // single block: read head, then shift the list down one place
            S_POP_RD: begin
                o_fl_raddr = '0;
                n_start = '0;
                n_len = NW'(1);
                n_i = CW'(1);
                n_j = '0;
                n_state = S_POP_WR;
            end
            S_POP_WR: begin
                n_first = i_fl_rdata;
                n_base = {1'b0, i_fl_rdata};
                n_i = CW'(1);
                n_state = S_CMP_RD;
            end
            // insertion sort, one element per pass
            S_SORT_RD_I: begin
                if (r_i >= r_cnt) begin
                    n_i = CW'(1); n_start = '0; n_len = NW'(1);
                    o_fl_raddr = '0;
                    n_state = S_SCAN_RD;
                end else begin
                    o_fl_raddr = r_i[AW-1:0];
                    n_state = S_SORT_WAIT_I;
                end
            end
            S_SORT_WAIT_I: begin
                n_v = i_fl_rdata;
                n_j = r_i;
                n_state = S_SORT_RD_J;
            end
            S_SORT_RD_J: begin
                if (r_j == '0) begin
                    n_state = S_SORT_PUT;
                end else begin
                    o_fl_raddr = AW'(r_j - CW'(1));
                    n_state = S_SORT_CMP;
                end
            end
            S_SORT_CMP: begin
                if (i_fl_rdata > r_v) begin
                    o_fl_we = 1'b1; o_fl_waddr = r_j[AW-1:0]; o_fl_wdata = i_fl_rdata;
                    n_j = r_j - CW'(1);
                    n_state = S_SORT_RD_J;
                end else begin
                    n_state = S_SORT_PUT;
                end
            end
            S_SORT_PUT: begin
                o_fl_we = 1'b1; o_fl_waddr = r_j[AW-1:0]; o_fl_wdata = r_v;
                n_i = r_i + CW'(1);
                n_state = S_SORT_RD_I;
            end
            // run scan: entry 0 is being read on entry
            S_SCAN_RD: begin
                n_base = {1'b0, i_fl_rdata};
                if (r_i < r_cnt && r_len < r_need) begin
                    o_fl_raddr = r_i[AW-1:0];
                    n_state = S_SCAN_CMP;
                end else if (r_len == r_need) begin
                    n_first = r_base[AW-1:0];
                    n_i = r_start + CW'(r_need);
                    n_j = r_start;
                    n_state = S_CMP_RD;
                end else begin
                    n_rsp.status = ST_NO_RUN; n_state = S_DONE;
                end
                if (r_state == S_SCAN_RD && r_i != CW'(1)) begin
                    n_base = r_base;
                end
            end
            S_SCAN_CMP: begin
                if (EW'(r_base) + EW'(r_len) == EW'(i_fl_rdata)) begin
                    n_len = r_len + NW'(1);
                end else begin
                    n_start = r_i;
                    n_len = NW'(1);
                    n_base = {1'b0, i_fl_rdata};
                    n_first = i_fl_rdata;
                end
                n_i = r_i + CW'(1);
                n_state = S_SCAN_RD;
            end
            // compact list: move entries from r_i down to r_j
            S_CMP_RD: begin
                if (r_i >= r_cnt) begin
                    n_state = S_REC;
                end else begin
                    o_fl_raddr = r_i[AW-1:0];
                    n_state = S_CMP_WR;
                end
            end
            S_CMP_WR: begin
                o_fl_we = 1'b1; o_fl_waddr = r_j[AW-1:0]; o_fl_wdata = i_fl_rdata;
                n_i = r_i + CW'(1);
                n_j = r_j + CW'(1);
                n_state = S_CMP_RD;
            end
            S_REC: begin
                o_rl_we = 1'b1; o_rl_waddr = r_first; o_rl_wdata = CW'(r_need);
                n_cnt = r_cnt - CW'(r_need);
                n_rsp.status = ST_OK;
                n_rsp.first_block = 8'(r_first);
                n_rsp.block_count = 9'(r_need);
                n_state = S_DONE;
            end
            // free: read recorded run length
            S_FREE_RD: begin
                o_rl_raddr = AW'(r_req.block_index);
                n_state = S_FREE_CHK;
            end
            S_FREE_CHK: begin
                n_used = i_rl_rdata;
                if (EW'(r_cnt) + EW'(i_rl_rdata) > EW'(BLOCKS)
                    || EW'(r_req.block_index) + EW'(i_rl_rdata) > EW'(BLOCKS)) begin
                    n_rsp.status = ST_OVERFLOW; n_state = S_DONE;
                end else begin
                    n_i = '0;
                    n_state = S_FREE_WR;
                end
            end
            S_FREE_WR: begin
                if (r_i >= r_used) begin
                    n_cnt = r_cnt + r_used;
                    n_rsp.status = ST_OK;
                    n_rsp.block_count = 9'(r_used);
                    n_state = S_DONE;
                end else begin
                    o_fl_we = 1'b1;
                    o_fl_waddr = AW'(r_cnt + r_i);
                    o_fl_wdata = AW'(EW'(r_req.block_index) + EW'(r_i));
                    n_i = r_i + CW'(1);
                end
            end
            S_DONE: begin
                o_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_rsp = r_rsp;
endmodule
`default_nettype wire

>>> hdl/cba_checker.sv
// Port-level checker for the allocator, bound to the top level.
// Depends on cba_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "contiguous_block_allocator_unit_assert.svh"
module cba_checker
    import cba_pkg::*;
(
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  start,
    input wire  busy,
    input wire  o_done,
    input t_rsp o_rsp
);
    `CBA_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised")
    `CBA_ASSERT_IMP(a_done_busy, i_clk, i_rst_n, o_done, busy, "result while idle")
    `CBA_ASSERT_NEXT(a_done_free, i_clk, i_rst_n, o_done, !busy && !o_done, "no release")
    `CBA_ASSERT_IMP(a_status, i_clk, i_rst_n, o_done, o_rsp.status <= ST_NULL, "bad status")
    `CBA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && o_rsp.status != ST_OK,
        o_rsp.block_count == 9'd0 && o_rsp.first_block == 8'd0, "fail fields")
endmodule
bind contiguous_block_allocator_unit cba_checker u_cba_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_rsp(o_rsp)
);
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the contiguous block allocator unit.
// Depends on cba_pkg and the contiguous_block_allocator_unit RTL; an internal
// pool model predicts every result, and responses are checked in order.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import cba_pkg::*;

    localparam int NBLK      = 256;
    localparam int BLK_BYTES = 64;
    localparam int IDLE_MAX  = 400000;
    localparam int N_RANDOM  = 1150;

    // Shadow of the allocator state: free list, its fill and recorded runs
    typedef struct {
        logic [7:0] list [NBLK];
        int         count;
        int         run [NBLK];
    } t_pool;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    t_req i_req = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    contiguous_block_allocator_unit #(.BLOCKS(NBLK), .BLOCK_BYTES(BLK_BYTES)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    t_pool live_pool;
    t_pool gen_pool;
    t_req  req_q[$];
    bit    drain_q[$];
    t_rsp  rsp_due[$];
    int    mismatches = 0;
    int    gap = 0;
    int    idle_cycles = 0;
    bit    all_loaded = 1'b0;
    logic [7:0] handles[$];

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void pool_reset(ref t_pool p);
        for (int i = 0; i < NBLK; i++) begin
            p.list[i] = i[7:0];
            p.run[i] = 0;
        end
        p.count = NBLK;
    endfunction

    // Apply one request to a pool and return the response it produces
    function automatic t_rsp pool_step(ref t_pool p, input t_req r);
        t_rsp rsp;
        int need;
        int used;
        int idx;
        int j;
        int run_start;
        int len;
        logic [7:0] v;
        logic [7:0] first;
        rsp = '0;
        if (r.cmd == CMD_ALLOC) begin
            need = int'(r.request_bytes) / BLK_BYTES + 1;
            if (p.count == 0) begin
                rsp.status = ST_EMPTY;
            end else if (need > p.count) begin
                rsp.status = ST_NO_RUN;
            end else if (need == 1) begin
                first = p.list[0];
                for (int i = 1; i < p.count; i++) p.list[i-1] = p.list[i];
                p.count--;
                p.run[first] = 1;
                rsp.status = ST_OK;
                rsp.first_block = first;
                rsp.block_count = 9'd1;
            end else begin
                // insertion sort ascending, then first-fit run scan
                for (int i = 1; i < p.count; i++) begin
                    v = p.list[i];
                    j = i;
                    while (j > 0 && p.list[j-1] > v) begin
                        p.list[j] = p.list[j-1];
                        j--;
                    end
                    p.list[j] = v;
                end
                run_start = 0;
                len = 1;
                for (int i = 1; i < p.count && len < need; i++) begin
                    if (int'(p.list[i]) == int'(p.list[run_start]) + len) begin
                        len++;
                    end else begin
                        run_start = i;
                        len = 1;
                    end
                end
                if (len != need) begin
                    rsp.status = ST_NO_RUN;
                end else begin
                    first = p.list[run_start];
                    for (int i = run_start + need; i < p.count; i++)
                        p.list[i-need] = p.list[i];
                    p.count -= need;
                    p.run[first] = need;
                    rsp.status = ST_OK;
                    rsp.first_block = first;
                    rsp.block_count = need[8:0];
                end
            end
        end else begin
            idx = int'(r.block_index);
            if (r.null_handle) begin
                rsp.status = ST_NULL;
            end else if (idx >= NBLK) begin
                rsp.status = ST_BAD_IDX;
            end else begin
                used = p.run[idx];
                if (p.count + used > NBLK || idx + used > NBLK) begin
                    rsp.status = ST_OVERFLOW;
                end else begin
                    for (int i = 0; i < used; i++) p.list[p.count+i] = 8'(idx + i);
                    p.count += used;
                    rsp.status = ST_OK;
                    rsp.block_count = used[8:0];
                end
            end
        end
        return rsp;
    endfunction

    // Queue one request and track live handles so frees hit real runs
    task automatic add_req(input t_req r, input bit drain);
        t_rsp rsp;
        rsp = pool_step(gen_pool, r);
        if (r.cmd == CMD_ALLOC && rsp.status == ST_OK)
            handles.insert(handles.size(), rsp.first_block);
        req_q.insert(req_q.size(), r);
        drain_q.insert(drain_q.size(), drain);
    endtask

    function automatic t_req mk_req(input logic c, input int bytes, input int idx,
                                    input logic nul);
        t_req r;
        r.cmd = c;
        r.request_bytes = bytes[13:0];
        r.block_index = idx[7:0];
        r.null_handle = nul;
        return r;
    endfunction

    // Fill the request queue: directed corners first, then random traffic
    initial begin
        t_req r;
        int sel;
        int pick;
        pool_reset(gen_pool);
        pool_reset(live_pool);
        add_req(mk_req(CMD_ALLOC, 0, 255, 1'b1), 1'b0);      // single block, front pop
        add_req(mk_req(CMD_FREE, 16383, 0, 1'b0), 1'b0);     // return it to the back
        add_req(mk_req(CMD_ALLOC, 127, 0, 1'b0), 1'b0);      // two blocks, sorts list
        add_req(mk_req(CMD_FREE, 0, 255, 1'b0), 1'b0);       // unrecorded block
        add_req(mk_req(CMD_FREE, 0, 0, 1'b1), 1'b0);         // null handle
        add_req(mk_req(CMD_FREE, 0, 0, 1'b0), 1'b0);         // repeated free
        add_req(mk_req(CMD_ALLOC, 16383, 0, 1'b0), 1'b1);    // whole pool, 256 blocks
        add_req(mk_req(CMD_FREE, 0, 1, 1'b0), 1'b0);
        add_req(mk_req(CMD_FREE, 0, 0, 1'b0), 1'b0);         // returns the whole-pool run
        add_req(mk_req(CMD_ALLOC, 16383, 0, 1'b0), 1'b0);    // whole pool again, list is contiguous
        pool_reset(gen_pool);
        handles.delete();
        // rebuild from a known state: clear the queue and queue the directed list again
        req_q.delete();
        drain_q.delete();
        add_req(mk_req(CMD_ALLOC, 0, 255, 1'b1), 1'b0);
        add_req(mk_req(CMD_FREE, 16383, 0, 1'b0), 1'b0);
        add_req(mk_req(CMD_ALLOC, 127, 0, 1'b0), 1'b0);
        add_req(mk_req(CMD_FREE, 0, 255, 1'b0), 1'b0);
        add_req(mk_req(CMD_FREE, 0, 0, 1'b1), 1'b0);
        add_req(mk_req(CMD_FREE, 0, 0, 1'b0), 1'b0);
        add_req(mk_req(CMD_ALLOC, 16383, 0, 1'b0), 1'b1);
        add_req(mk_req(CMD_FREE, 0, 1, 1'b0), 1'b0);
        add_req(mk_req(CMD_FREE, 0, 0, 1'b0), 1'b0);
        add_req(mk_req(CMD_ALLOC, 16383, 0, 1'b0), 1'b0);
        add_req(mk_req(CMD_ALLOC, 16320, 0, 1'b0), 1'b0);    // 256 blocks, whole pool
        add_req(mk_req(CMD_ALLOC, 0, 0, 1'b0), 1'b0);        // empty pool
        add_req(mk_req(CMD_FREE, 0, 2, 1'b0), 1'b0);
        add_req(mk_req(CMD_ALLOC, 100, 0, 1'b0), 1'b0);
        handles.delete();
        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 99);
            r = mk_req(CMD_ALLOC, $urandom_range(0, 16383), $urandom_range(0, 255),
                       1'($urandom_range(0, 1)));
            if (sel < 45) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) r.request_bytes = 14'($urandom_range(0, 63));
                else if (pick < 90) r.request_bytes = 14'($urandom_range(64, 511));
                else if (pick < 98) r.request_bytes = 14'($urandom_range(512, 4095));
            end else if (sel < 90) begin
                r.cmd = CMD_FREE;
                r.null_handle = 1'b0;
                if (handles.size() != 0 && $urandom_range(0, 4) != 0) begin
                    pick = $urandom_range(0, handles.size() - 1);
                    r.block_index = handles[pick];
                    if ($urandom_range(0, 6) != 0) handles.delete(pick);
                end
            end else begin
                r.cmd = CMD_FREE;
                r.null_handle = 1'b1;
            end
            add_req(r, n == N_RANDOM / 2);
        end
        all_loaded = 1'b1;
    end

    // Reset: hold low at start, release once, never again
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: issue requests with random gaps, predicting each at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else if (start && !busy) begin
            rsp_due.insert(rsp_due.size(), pool_step(live_pool, i_req));
            start <= 1'b0;
        end else if (!start) begin
            if (gap > 0) begin
                gap <= gap - 1;
            end else if (req_q.size() != 0 && !(drain_q[0] && rsp_due.size() != 0)) begin
                i_req <= req_q[0];
                req_q.delete(0);
                drain_q.delete(0);
                start <= 1'b1;
                gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            end
        end
    end

    // Monitor: check each response against the oldest prediction
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_done) begin
            if (rsp_due.size() == 0) begin
                $error("unexpected response status=%0d", o_rsp.status);
                mismatches++;
            end else begin
                exp_rsp = rsp_due[0];
                rsp_due.delete(0);
                if (o_rsp.status !== exp_rsp.status) begin
                    $error("status exp=%0d got=%0d", exp_rsp.status, o_rsp.status);
                    mismatches++;
                end
                if (o_rsp.first_block !== exp_rsp.first_block) begin
                    $error("first_block exp=%0d got=%0d", exp_rsp.first_block,
                           o_rsp.first_block);
                    mismatches++;
                end
                if (o_rsp.block_count !== exp_rsp.block_count) begin
                    $error("block_count exp=%0d got=%0d", exp_rsp.block_count,
                           o_rsp.block_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles with no request or response moving
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // End of run: drain, allow latency to settle, then report
    initial begin
        wait (all_loaded && i_rst_n);
        do @(posedge i_clk);
        while (req_q.size() != 0 || start || rsp_due.size() != 0);
        repeat (600) @(posedge i_clk);
        if (rsp_due.size() != 0) begin
            $error("%0d responses never arrived", rsp_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
